>>> design/pba_pkg.sv
// shared types and constants for the polygon bounds accumulator
package pba_pkg;

  // result fields are fixed at this width whatever the coordinate width
  localparam int OUT_WIDTH = 16;

  // vertex count saturates here; below it the polygon has too few vertices
  localparam logic [1:0] COUNT_SAT = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_UPDATE = 5'b00010,
    S_LAUNCH = 5'b00100,
    S_ROOT   = 5'b01000,
    S_FINISH = 5'b10000
  } pba_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic update;
    logic root_start;
    logic load_out;
  } pba_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic last;
    logic out_busy;
  } pba_sts_t;

endpackage

>>> design/pba_vertex_if.sv
// vertex channel: valid/ready handshake with one polygon vertex per item
interface pba_vertex_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;
  logic                          last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                  output ready);
endinterface

>>> design/pba_result_if.sv
// result channel: valid/ready handshake with one polygon summary per item
interface pba_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pba_pkg::OUT_WIDTH-1:0] box_min_x;
  logic signed [pba_pkg::OUT_WIDTH-1:0] box_min_y;
  logic signed [pba_pkg::OUT_WIDTH-1:0] box_max_x;
  logic signed [pba_pkg::OUT_WIDTH-1:0] box_max_y;
  logic signed [pba_pkg::OUT_WIDTH-1:0] center_x;
  logic signed [pba_pkg::OUT_WIDTH-1:0] center_y;
  logic        [pba_pkg::OUT_WIDTH-1:0] max_radius;
  logic                                 too_few;

  modport source (output valid, output box_min_x, output box_min_y, output box_max_x,
                  output box_max_y, output center_x, output center_y,
                  output max_radius, output too_few, input ready);
  modport sink   (input valid, input box_min_x, input box_min_y, input box_max_x,
                  input box_max_y, input center_x, input center_y,
                  input max_radius, input too_few, output ready);
endinterface

>>> design/pba_isqrt.sv
// iterative floor square root, one result bit per cycle
module pba_isqrt #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [2*COORD_WIDTH-1:0]   value,
  output logic                       done,
  output logic [COORD_WIDTH-1:0]     root
);
  localparam int W  = COORD_WIDTH;
  localparam int CW = $clog2(W + 1);

  logic [2*W-1:0] val;
  logic [W+1:0]   rem;
  logic [CW-1:0]  cnt;
  logic           active;

  logic [W+3:0]   trial;
  logic [W+3:0]   sub;
  logic           ge;
  logic [W+3:0]   diff;

  always_comb begin
    trial = {rem, val[2*W-1 -: 2]};
    sub   = (W+4)'({root, 2'b01});
    ge    = trial >= sub;
    diff  = trial - sub;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CW'(W);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val  <= value;
      rem  <= '0;
      root <= '0;
    end else if (active) begin
      val  <= val << 2;
      rem  <= ge ? diff[W+1:0] : trial[W+1:0];
      root <= {root[W-2:0], ge};
    end
  end

endmodule

>>> design/pba_ctrl.sv
// controller state machine: sequences capture, update, square root and output load
module pba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              root_done,
  input  pba_pkg::pba_sts_t sts,
  output pba_pkg::pba_cmd_t cmd
);
  import pba_pkg::*;

  pba_state_t state;
  pba_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = sts.last ? S_LAUNCH : S_IDLE;
      end
      S_LAUNCH: begin
        cmd.root_start = 1'b1;
        state_next     = S_ROOT;
      end
      S_ROOT: begin
        if (root_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !sts.out_busy)
    else $error("output loaded while the previous result is still held");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.update, cmd.root_start, cmd.load_out}))
    else $error("more than one datapath command at once");

  a_done_in_root: assert property (@(posedge clk) disable iff (rst)
    root_done |-> state == S_ROOT)
    else $error("square root finished outside the root state");

endmodule

>>> design/pba_dpath.sv
// datapath: vertex squares, running box and distance, count and output register
module pba_dpath #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pba_pkg::pba_cmd_t                    cmd,
  output pba_pkg::pba_sts_t                    sts,
  input  logic signed [COORD_WIDTH-1:0]        vertex_x,
  input  logic signed [COORD_WIDTH-1:0]        vertex_y,
  input  logic                                 last_vertex,
  output logic [2*COORD_WIDTH-1:0]             max_dist,
  input  logic [COORD_WIDTH-1:0]               root,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pba_pkg::OUT_WIDTH-1:0] box_min_x,
  output logic signed [pba_pkg::OUT_WIDTH-1:0] box_min_y,
  output logic signed [pba_pkg::OUT_WIDTH-1:0] box_max_x,
  output logic signed [pba_pkg::OUT_WIDTH-1:0] box_max_y,
  output logic signed [pba_pkg::OUT_WIDTH-1:0] center_x,
  output logic signed [pba_pkg::OUT_WIDTH-1:0] center_y,
  output logic        [pba_pkg::OUT_WIDTH-1:0] max_radius,
  output logic                                 too_few
);
  import pba_pkg::*;

  localparam int W = COORD_WIDTH;

  // captured vertex
  logic signed [W-1:0] x_q;
  logic signed [W-1:0] y_q;
  logic                last_q;
  logic [2*W-1:0]      sq_x_q;
  logic [2*W-1:0]      sq_y_q;

  // running state
  logic signed [W-1:0] min_x;
  logic signed [W-1:0] min_y;
  logic signed [W-1:0] max_x;
  logic signed [W-1:0] max_y;
  logic [1:0]          count;

  logic [W-1:0]        ax;
  logic [W-1:0]        ay;
  logic [2*W-1:0]      sq_x;
  logic [2*W-1:0]      sq_y;
  logic [2*W-1:0]      dist_sq;
  logic                seed;
  logic signed [W:0]   sum_x;
  logic signed [W:0]   sum_y;
  logic signed [W:0]   half_x;
  logic signed [W:0]   half_y;

  always_comb begin
    ax      = vertex_x[W-1] ? W'(~unsigned'(vertex_x) + 1'b1) : unsigned'(vertex_x);
    ay      = vertex_y[W-1] ? W'(~unsigned'(vertex_y) + 1'b1) : unsigned'(vertex_y);
    sq_x    = ax * ax;
    sq_y    = ay * ay;
    dist_sq = sq_x_q + sq_y_q;
    seed    = (count == '0);
    sum_x   = (W+1)'(min_x) + (W+1)'(max_x);
    sum_y   = (W+1)'(min_y) + (W+1)'(max_y);
    half_x  = sum_x >>> 1;
    half_y  = sum_y >>> 1;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_q    <= vertex_x;
      y_q    <= vertex_y;
      last_q <= last_vertex;
      sq_x_q <= sq_x;
      sq_y_q <= sq_y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (seed || x_q < min_x) min_x <= x_q;
      if (seed || x_q > max_x) max_x <= x_q;
      if (seed || y_q < min_y) min_y <= y_q;
      if (seed || y_q > max_y) max_y <= y_q;
      if (seed || dist_sq > max_dist) max_dist <= dist_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load_out) begin
      count <= '0;
    end else if (cmd.update && count != COUNT_SAT) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      box_min_x  <= OUT_WIDTH'(min_x);
      box_min_y  <= OUT_WIDTH'(min_y);
      box_max_x  <= OUT_WIDTH'(max_x);
      box_max_y  <= OUT_WIDTH'(max_y);
      center_x   <= OUT_WIDTH'(half_x);
      center_y   <= OUT_WIDTH'(half_y);
      max_radius <= OUT_WIDTH'(root);
      too_few    <= (count != COUNT_SAT);
    end
  end

  assign sts.last     = last_q;
  assign sts.out_busy = out_valid && !out_ready;

endmodule

>>> design/polygon_bounds_accumulator_unit.sv
// top level of the polygon bounds accumulator
//
//   channel  dir  item                 fields
//   vertex   in   one vertex           vertex_x, vertex_y, last_vertex
//   result   out  one polygon summary  box_min/max_x/y, center_x/y,
//                                      max_radius, too_few
//
// a vertex that is not marked last goes through capture, with the two
// squares registered, then the box, distance and count update
// the last vertex also goes through a launch state, the bit-per-cycle
// square root and its done flag, and the load of the output register,
// which waits while the previous result is still held, before the next
// vertex is taken
// the result sits in an output register; the next polygon streams in while
// it waits, and only a second finished result stalls on a full register
// rst is synchronous and active high; it clears the state machine, the
// vertex count and the output valid
module polygon_bounds_accumulator_unit #(
  parameter int COORD_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  pba_vertex_if.sink  vertex,
  pba_result_if.source result
);
  import pba_pkg::*;

  // command and status between controller and datapath
  pba_cmd_t cmd;
  pba_sts_t sts;

  // square root unit hookup
  logic [2*COORD_WIDTH-1:0] max_dist;
  logic [COORD_WIDTH-1:0]   root;
  logic                     root_done;

  // controller only takes a vertex when it is back in idle
  pba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vertex.valid),
    .in_ready  (vertex.ready),
    .root_done (root_done),
    .sts       (sts),
    .cmd       (cmd)
  );

  // running box, largest squared distance and the output register
  pba_dpath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .vertex_x     (vertex.vertex_x),
    .vertex_y     (vertex.vertex_y),
    .last_vertex  (vertex.last_vertex),
    .max_dist     (max_dist),
    .root         (root),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .box_min_x    (result.box_min_x),
    .box_min_y    (result.box_min_y),
    .box_max_x    (result.box_max_x),
    .box_max_y    (result.box_max_y),
    .center_x     (result.center_x),
    .center_y     (result.center_y),
    .max_radius   (result.max_radius),
    .too_few      (result.too_few)
  );

  // bounding radius: started once the last vertex has been folded in
  pba_isqrt #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.root_start),
    .value (max_dist),
    .done  (root_done),
    .root  (root)
  );

endmodule

>>> dv/pba_bounds_checker.sv
`timescale 1ns / 1ps
// watches the vertex and result channels, predicts each polygon summary and compares it
module pba_bounds_checker (
  input  logic  clk,
  input  logic  rst,
  pba_vertex_if vertex,
  pba_result_if result,
  output int    mismatch_count,
  output int    pending_results,
  output int    summaries_checked
);
  import pba_pkg::*;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] min_x;
    logic signed [OUT_WIDTH-1:0] min_y;
    logic signed [OUT_WIDTH-1:0] max_x;
    logic signed [OUT_WIDTH-1:0] max_y;
    logic signed [OUT_WIDTH-1:0] cen_x;
    logic signed [OUT_WIDTH-1:0] cen_y;
    logic        [OUT_WIDTH-1:0] radius;
    logic                        too_few;
  } poly_bounds_t;

  // summaries of finished polygons not yet seen on the result channel
  poly_bounds_t expected_bounds[$];

  // running box of the polygon being streamed in (16-bit coordinates)
  logic signed [OUT_WIDTH-1:0] run_min_x, run_min_y, run_max_x, run_max_y;
  logic        [31:0]          run_dist_sq;
  logic        [1:0]           seen_count;

  function automatic logic [OUT_WIDTH-1:0] floor_root(input logic [31:0] sq);
    logic [OUT_WIDTH-1:0] root;
    logic [OUT_WIDTH-1:0] trial;
    root = '0;
    for (int b = OUT_WIDTH - 1; b >= 0; b--) begin
      trial = root;
      trial[b] = 1'b1;
      if (longint'(trial) * longint'(trial) <= longint'(sq)) root = trial;
    end
    return root;
  endfunction

  // arithmetic shift of the exact sum rounds toward minus infinity
  function automatic logic signed [OUT_WIDTH-1:0] floor_mid(
    input logic signed [OUT_WIDTH-1:0] lo, hi);
    longint sum;
    sum = longint'(lo) + longint'(hi);
    return OUT_WIDTH'(sum >>> 1);
  endfunction

  task automatic clear_polygon();
    run_min_x   = '0;
    run_min_y   = '0;
    run_max_x   = '0;
    run_max_y   = '0;
    run_dist_sq = '0;
    seen_count  = '0;
  endtask

  task automatic absorb_vertex(input logic signed [OUT_WIDTH-1:0] x, y, input logic lst);
    longint       xs, ys;
    logic [31:0]  dist_sq;
    poly_bounds_t summary;
    xs      = x;
    ys      = y;
    dist_sq = 32'(xs * xs + ys * ys);
    if (seen_count == 2'd0) begin
      run_min_x   = x;
      run_max_x   = x;
      run_min_y   = y;
      run_max_y   = y;
      run_dist_sq = dist_sq;
    end else begin
      if (x < run_min_x) run_min_x = x;
      if (x > run_max_x) run_max_x = x;
      if (y < run_min_y) run_min_y = y;
      if (y > run_max_y) run_max_y = y;
      if (dist_sq > run_dist_sq) run_dist_sq = dist_sq;
    end
    if (seen_count < COUNT_SAT) seen_count++;
    if (lst) begin
      summary.min_x   = run_min_x;
      summary.min_y   = run_min_y;
      summary.max_x   = run_max_x;
      summary.max_y   = run_max_y;
      summary.cen_x   = floor_mid(run_min_x, run_max_x);
      summary.cen_y   = floor_mid(run_min_y, run_max_y);
      summary.radius  = floor_root(run_dist_sq);
      summary.too_few = (seen_count < COUNT_SAT);
      expected_bounds.push_back(summary);
      clear_polygon();
    end
  endtask

  task automatic check_field(input string field, input logic [OUT_WIDTH-1:0] want, got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%h, got 0x%h", field, want, got);
      mismatch_count++;
    end
  endtask

  task automatic compare_bounds();
    poly_bounds_t want;
    if (expected_bounds.size() == 0) begin
      $error("result item with no finished polygon outstanding");
      mismatch_count++;
    end else begin
      want = expected_bounds.pop_front();
      check_field("box_min_x", want.min_x, result.box_min_x);
      check_field("box_min_y", want.min_y, result.box_min_y);
      check_field("box_max_x", want.max_x, result.box_max_x);
      check_field("box_max_y", want.max_y, result.box_max_y);
      check_field("center_x", want.cen_x, result.center_x);
      check_field("center_y", want.cen_y, result.center_y);
      check_field("max_radius", want.radius, result.max_radius);
      check_field("too_few", OUT_WIDTH'(want.too_few), OUT_WIDTH'(result.too_few));
      summaries_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_polygon();
    end else begin
      if (result.valid && result.ready) compare_bounds();
      if (vertex.valid && vertex.ready)
        absorb_vertex(vertex.vertex_x, vertex.vertex_y, vertex.last_vertex);
    end
    pending_results <= expected_bounds.size();
  end

endmodule

>>> dv/tb_polygon_bounds_accumulator_unit.sv
`timescale 1ns / 1ps
// testbench top: streams polygons into the accumulator, paces the result side, gives the verdict
module tb_polygon_bounds_accumulator_unit;
  import pba_pkg::*;

  localparam int COORD_W       = 16;
  localparam int CYCLE_LIMIT   = 200000;
  // the last vertex of a polygon runs through the square root, so wait longer than that
  localparam int SETTLE_CYCLES = COORD_W + 8;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE1_ITEMS  = 250;
  localparam int TOTAL_ITEMS   = 550;

  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  logic clk = 1'b0;
  logic rst;

  always #6 clk = ~clk;

  pba_vertex_if #(.COORD_WIDTH(COORD_W)) vertex ();
  pba_result_if                          result ();

  polygon_bounds_accumulator_unit #(.COORD_WIDTH(COORD_W)) dut (
    .clk    (clk),
    .rst    (rst),
    .vertex (vertex),
    .result (result)
  );

  int mismatches;
  int pending_results;
  int summaries_checked;

  pba_bounds_checker bounds_check (
    .clk               (clk),
    .rst               (rst),
    .vertex            (vertex),
    .result            (result),
    .mismatch_count    (mismatches),
    .pending_results   (pending_results),
    .summaries_checked (summaries_checked)
  );

  // bookkeeping for the closing summary
  int vertices_sent = 0;
  int polygons_sent = 0;
  int singles_sent  = 0;

  // raised by the stimulus to ask the result side for one long hold-off
  int hold_requests = 0;

  // polygon streamed back to back, no gaps between its vertices
  bit quick_polygon = 1'b0;

  // watchdog on a free-running cycle count
  int unsigned cycle_count = 0;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[polygon_bounds_accumulator_unit] ERROR");
    $finish;
  end

  // coordinates: mostly full range, some corners and some close to the origin
  function automatic logic signed [COORD_W-1:0] rand_coord();
    logic signed [COORD_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       v = C_MIN;
          1:       v = C_MAX;
          2:       v = '0;
          3:       v = '1;
          default: v = COORD_W'(1);
        endcase
      end
      1, 2:    v = COORD_W'($urandom_range(0, 32) - 16);
      default: v = COORD_W'($urandom);
    endcase
    return v;
  endfunction

  // mostly short polygons, some single vertices, now and then a long one
  function automatic int draw_length();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 3) return 1;
    if (roll < 5) return $urandom_range(10, 30);
    return $urandom_range(2, 6);
  endfunction

  // one vertex item; the gap before it is drawn fresh unless the polygon is quick
  task automatic send_vertex(input logic signed [COORD_W-1:0] x, y, input logic lst);
    int gap;
    gap = quick_polygon ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      vertex.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vertex.valid       <= 1'b1;
    vertex.vertex_x    <= x;
    vertex.vertex_y    <= y;
    vertex.last_vertex <= lst;
    do @(posedge clk); while (!vertex.ready);
    vertices_sent++;
    if (lst) polygons_sent++;
  endtask

  task automatic send_polygon(input int len, input bit quick);
    quick_polygon = quick;
    for (int i = 0; i < len; i++) send_vertex(rand_coord(), rand_coord(), i == len - 1);
    if (len == 1) singles_sent++;
    quick_polygon = 1'b0;
  endtask

  // stop offering vertices until every finished polygon has come out
  task automatic drain_results();
    vertex.valid <= 1'b0;
    @(posedge clk);
    wait (pending_results == 0);
    @(posedge clk);
  endtask

  // result side: random stall per item, gapless runs, and the long hold when asked
  initial begin
    int stall;
    int fast_left;
    int holds_served;
    fast_left    = 0;
    holds_served = 0;
    result.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (holds_served < hold_requests) begin
        stall = LONG_HOLD;
        holds_served++;
      end else if (fast_left > 0) begin
        stall = 0;
        fast_left--;
      end else if ($urandom_range(0, 7) == 0) begin
        stall     = 0;
        fast_left = 12;
      end else begin
        stall = $urandom_range(0, 11);
      end
      if (stall != 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!result.valid);
    end
  end

  // main stimulus
  initial begin
    rst                <= 1'b1;
    vertex.valid       <= 1'b0;
    vertex.vertex_x    <= '0;
    vertex.vertex_y    <= '0;
    vertex.last_vertex <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // single-vertex polygons: box collapses onto the vertex, too_few set
    send_vertex(0, 0, 1'b1);
    send_vertex(C_MIN, C_MIN, 1'b1);
    send_vertex(C_MAX, C_MAX, 1'b1);
    send_vertex(-1, -1, 1'b1);
    singles_sent += 4;
    // opposite corners: center sum is -1, so floor gives -1
    send_vertex(C_MIN, C_MAX, 1'b0);
    send_vertex(C_MAX, C_MIN, 1'b1);
    send_vertex(C_MIN, C_MIN, 1'b0);
    send_vertex(C_MAX, C_MAX, 1'b1);
    // negative odd sums round down
    send_vertex(-3, -5, 1'b0);
    send_vertex(0, 0, 1'b1);
    send_vertex(-7, 3, 1'b0);
    send_vertex(4, -9, 1'b1);
    // diamond touching every axis extreme
    send_vertex(C_MIN, 0, 1'b0);
    send_vertex(0, C_MIN, 1'b0);
    send_vertex(C_MAX, 0, 1'b0);
    send_vertex(0, C_MAX, 1'b1);
    // longer polygon, count saturates at two
    send_vertex(1, 1, 1'b0);
    send_vertex(-1, -1, 1'b0);
    send_vertex(2, -2, 1'b0);
    send_vertex(-2, 2, 1'b0);
    send_vertex(5, -7, 1'b1);
    // two identical vertices still count as two
    send_vertex(100, 100, 1'b0);
    send_vertex(100, 100, 1'b1);
    drain_results();

    // random polygons
    while (vertices_sent < PHASE1_ITEMS) send_polygon(draw_length(), $urandom_range(0, 5) == 0);

    // result side holds off while short polygons keep coming, so the output
    // register fills and the vertex channel has to stall
    hold_requests++;
    repeat (10) send_polygon(3, 1'b1);
    drain_results();

    while (vertices_sent < TOTAL_ITEMS) send_polygon(draw_length(), $urandom_range(0, 5) == 0);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d polygons from %0d vertices (%0d single-vertex),",
             polygons_sent, vertices_sent, singles_sent);
    $display("%0d summaries checked; result side held off %0d cycles once, %s",
             summaries_checked, LONG_HOLD, "vertex side drained three times");
    if (mismatches == 0 && pending_results == 0) begin
      $display("[polygon_bounds_accumulator_unit] OK");
    end else begin
      $display("[polygon_bounds_accumulator_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> polygon_bounds_accumulator_unit.f
design/pba_pkg.sv
design/pba_vertex_if.sv
design/pba_result_if.sv
design/pba_isqrt.sv
design/pba_ctrl.sv
design/pba_dpath.sv
design/polygon_bounds_accumulator_unit.sv
dv/pba_bounds_checker.sv
dv/tb_polygon_bounds_accumulator_unit.sv
